FILE: src/srb_pkg.sv
// Shared constants and types for the sequence reorder buffer.
`timescale 1ns / 1ps
package srb_pkg;

    localparam int DEPTH_DEF    = 64;
    localparam int SEQ_BITS_DEF = 32;
    localparam int MODE_W       = 2;
    localparam int NUM_W        = 32;

    typedef logic [MODE_W-1:0] t_mode;
    typedef logic [NUM_W-1:0]  t_num;

    localparam t_mode MODE_ADD  = 2'd0;
    localparam t_mode MODE_TAKE = 2'd1;
    localparam t_mode MODE_SET  = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_LOOK  = 3'b100
    } t_state;

endpackage

FILE: src/srb_if.sv
// Request and delivery channel interfaces of the sequence reorder buffer.
`timescale 1ns / 1ps
interface srb_in_if;
    import srb_pkg::*;
    logic  valid;
    logic  ready;
    t_mode mode;
    t_num  sequence_number;

    modport source (output valid, output mode, output sequence_number, input ready);
    modport sink   (input valid, input mode, input sequence_number, output ready);
endinterface

interface srb_out_if;
    import srb_pkg::*;
    logic valid;
    logic ready;
    t_num delivered_number;

    modport source (output valid, output delivered_number, input ready);
    modport sink   (input valid, input delivered_number, output ready);
endinterface

FILE: src/sequence_reorder_buffer_top.sv
// Top level of the sequence reorder buffer: control, counters and tag store.
`timescale 1ns / 1ps
// Sequence reorder buffer. Requests arrive on i_req (valid/ready, mode and
// sequence_number); in-order deliveries leave on o_dlv (valid/ready,
// delivered_number). An add writes the epoch tag of the number into its slot;
// a take delivers the expected number when its slot holds the matching epoch,
// otherwise it leaves a pending request that a later add of that exact number
// fills. A set loads the expected number unless a request is pending.
// Add and set, and a take ignored while a request is pending, finish on
// acceptance, so the next request can follow at once if the output register
// is free; a take that looks up its slot holds i_req.ready low in ST_LOOK,
// where the tag read from the single-port tag RAM (registered read data) is
// compared. An add's delivery shows on o_dlv the cycle after the request.
// Reset: i_rst_n (synchronous, active low) clears the counters, then a
// clearing pass writes every tag slot empty, one slot a cycle; i_req.ready
// stays low during it.
// Receiver stall: the delivery sits in an output register; new requests are
// taken while it waits only when that register drains in the same cycle.
module sequence_reorder_buffer_top #(
    parameter int DEPTH    = srb_pkg::DEPTH_DEF,
    parameter int SEQ_BITS = srb_pkg::SEQ_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    srb_in_if.sink    i_req,
    srb_out_if.source o_dlv
);

    import srb_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int TAG_W = SEQ_BITS - AW;
    localparam int WORD  = TAG_W + 1;   // valid bit on top of the epoch tag

    t_state                r_state, n_state;
    logic [AW-1:0]         r_clr_addr;
    logic [SEQ_BITS-1:0]   r_expected, n_expected;
    logic                  r_pending, n_pending;
    logic                  r_out_valid, n_out_valid;
    t_num                  r_out_num, n_out_num;

    logic                  w_accept;
    logic [SEQ_BITS-1:0]   w_num;
    logic [SEQ_BITS-1:0]   w_exp_inc;
    t_num                  w_exp_ext;
    logic                  w_hit;

    logic                  w_we;
    logic [AW-1:0]         w_addr;
    logic [WORD-1:0]       w_wdata;
    logic [WORD-1:0]       w_rdata;

    srb_ram #(
        .WIDTH (WORD),
        .DEPTH (DEPTH)
    ) u_tags (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    // Accept only when idle and the output register is free by the next edge.
    assign i_req.ready = (r_state == ST_IDLE) && (!r_out_valid || o_dlv.ready);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_num       = i_req.sequence_number[SEQ_BITS-1:0];
    assign w_exp_inc   = r_expected + 1'b1;

    always_comb begin
        w_exp_ext                 = '0;
        w_exp_ext[SEQ_BITS-1:0]   = r_expected;
    end

    // Tag compare on the read data of a take.
    assign w_hit = w_rdata[WORD-1] && (w_rdata[TAG_W-1:0] == r_expected[SEQ_BITS-1:AW]);

    // RAM port: clearing pass, add writes, take reads at the expected slot.
    always_comb begin
        w_we    = 1'b0;
        w_addr  = r_expected[AW-1:0];
        w_wdata = {1'b1, w_num[SEQ_BITS-1:AW]};
        if (r_state == ST_CLEAR) begin
            w_we    = 1'b1;
            w_addr  = r_clr_addr;
            w_wdata = '0;
        end else if (w_accept && i_req.mode == MODE_ADD) begin
            w_we   = 1'b1;
            w_addr = w_num[AW-1:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_expected  = r_expected;
        n_pending   = r_pending;
        n_out_valid = r_out_valid && !o_dlv.ready;
        n_out_num   = r_out_num;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_req.mode)
                        MODE_ADD: begin
                            if (r_pending && w_num == r_expected) begin
                                n_out_valid = 1'b1;
                                n_out_num   = w_exp_ext;
                                n_expected  = w_exp_inc;
                                n_pending   = 1'b0;
                            end
                        end
                        MODE_TAKE: begin
                            if (!r_pending) begin
                                n_state = ST_LOOK;
                            end
                        end
                        MODE_SET: begin
                            if (!r_pending) begin
                                n_expected = w_num;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LOOK: begin
                n_state = ST_IDLE;
                if (w_hit) begin
                    n_out_valid = 1'b1;
                    n_out_num   = w_exp_ext;
                    n_expected  = w_exp_inc;
                end else begin
                    n_pending = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_expected  <= '0;
            r_pending   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= (r_state == ST_CLEAR) ? r_clr_addr + 1'b1 : r_clr_addr;
            r_expected  <= n_expected;
            r_pending   <= n_pending;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_num <= n_out_num;
    end

    assign o_dlv.valid            = r_out_valid;
    assign o_dlv.delivered_number = r_out_num;

endmodule

FILE: src/srb_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module srb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: tb/srb_delivery_checker.sv
// Delivery checker for the sequence reorder buffer: predicts and compares deliveries.
`timescale 1ns / 1ps
module srb_delivery_checker #(
    parameter int DEPTH    = srb_pkg::DEPTH_DEF,
    parameter int SEQ_BITS = srb_pkg::SEQ_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    srb_in_if             i_req,
    srb_out_if            i_dlv,
    output int            o_fail_count,
    output int            o_outstanding,
    output logic          o_pending,
    output srb_pkg::t_num o_expected_number
);

    import srb_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int TAG_W = SEQ_BITS - IDX_W;

    logic [TAG_W-1:0]    epoch_tag [DEPTH];
    logic                slot_full [DEPTH];
    logic [SEQ_BITS-1:0] next_due;
    logic                take_waiting;
    t_num                due_numbers [$];
    int                  mismatches = 0;

    assign o_fail_count = mismatches;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic deliver_next();
        due_numbers.push_back(t_num'(next_due));
        next_due = next_due + 1'b1;
    endtask

    // Apply one accepted request to the shadow state.
    task automatic apply_request(input t_mode mode, input t_num raw);
        logic [SEQ_BITS-1:0] num;
        logic [IDX_W-1:0]    idx;
        num = raw[SEQ_BITS-1:0];
        case (mode)
            MODE_ADD: begin
                idx            = num[IDX_W-1:0];
                epoch_tag[idx] = num[SEQ_BITS-1:IDX_W];
                slot_full[idx] = 1'b1;
                if (take_waiting && num == next_due) begin
                    deliver_next();
                    take_waiting = 1'b0;
                end
            end
            MODE_TAKE: begin
                if (!take_waiting) begin
                    idx = next_due[IDX_W-1:0];
                    if (slot_full[idx] && epoch_tag[idx] == next_due[SEQ_BITS-1:IDX_W])
                        deliver_next();
                    else
                        take_waiting = 1'b1;
                end
            end
            MODE_SET: begin
                if (!take_waiting)
                    next_due = num;
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_num want;
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                epoch_tag[i] = '0;
                slot_full[i] = 1'b0;
            end
            next_due     = '0;
            take_waiting = 1'b0;
            due_numbers.delete();
        end else begin
            // Compare first: a delivery never belongs to a request taken at the same edge.
            if (i_dlv.valid && i_dlv.ready) begin
                if (due_numbers.size() == 0) begin
                    report_mismatch($sformatf("unexpected delivery %h", i_dlv.delivered_number));
                end else begin
                    want = due_numbers.pop_front();
                    if (i_dlv.delivered_number !== want)
                        report_mismatch($sformatf("delivered_number %h, want %h",
                                                  i_dlv.delivered_number, want));
                end
            end
            if (i_req.valid && i_req.ready)
                apply_request(i_req.mode, i_req.sequence_number);
        end
        o_outstanding     <= due_numbers.size();
        o_pending         <= take_waiting;
        o_expected_number <= t_num'(next_due);
    end

endmodule

FILE: tb/tb_sequence_reorder_buffer_top.sv
// Testbench top for the sequence reorder buffer: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_sequence_reorder_buffer_top;
    import srb_pkg::*;

    // Mode 3 has no meaning in the block; it must change nothing.
    localparam t_mode MODE_UNUSED  = 2'd3;
    localparam int    IDLE_MAX     = 16;
    localparam int    SETTLE_WAIT  = 4;    // covers a take's ST_LOOK step, plus margin
    localparam int    RANDOM_ITEMS = 450;
    localparam int    SEQ_MAX_LEN  = 8;    // well under DEPTH, so no slot collisions inside a run

    logic clk;
    logic rst_n;

    srb_in_if  req_if ();
    srb_out_if dlv_if ();

    int   fail_count;
    int   outstanding;
    logic model_pending;
    t_num model_expected;

    int   sent_count = 0;
    int   rx_hold    = 0;
    logic tx_eager   = 1'b0;
    logic rx_eager;
    t_num recent_base = '0;

    sequence_reorder_buffer_top u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_dlv   (dlv_if)
    );

    srb_delivery_checker u_chk (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_req             (req_if),
        .i_dlv             (dlv_if),
        .o_fail_count      (fail_count),
        .o_outstanding     (outstanding),
        .o_pending         (model_pending),
        .o_expected_number (model_expected)
    );

    initial clk = 1'b0;
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Delivery side: after each accepted delivery, hold ready low for a drawn number
    // of cycles. In eager stretches ready stays high after each delivery.
    always @(posedge clk) begin
        if (dlv_if.valid && dlv_if.ready)
            rx_hold = rx_eager ? 0 : $urandom_range(IDLE_MAX, 0);
        else if (rx_hold > 0)
            rx_hold--;
        dlv_if.ready <= (rx_hold == 0);
    end

    // One request: optional idle gap, then hold valid until the block takes it.
    // valid is left high on return so back-to-back requests need no second assignment.
    task automatic send_request(input t_mode mode, input t_num num);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(IDLE_MAX, 0);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid           <= 1'b1;
        req_if.mode            <= mode;
        req_if.sequence_number <= num;
        @(posedge clk);
        while (req_if.ready !== 1'b1) @(posedge clk);
        sent_count++;
    endtask

    // Stop sending and wait until every predicted delivery has come out. The
    // leading wait lets the checker's count catch up with the last request.
    task automatic drain_deliveries();
        req_if.valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    // A take left waiting blocks every later set, so fill it with the number it
    // waits for. The checker state is stable once everything has drained.
    task automatic settle_pending();
        drain_deliveries();
        if (model_pending)
            send_request(MODE_ADD, model_expected);
    endtask

    function automatic t_num pick_base();
        case ($urandom_range(3, 0))
            0:       return $urandom();
            1:       return 32'hFFFF_FFFF - $urandom_range(SEQ_MAX_LEN - 1, 0);  // can wrap inside the run
            2:       return $urandom_range(200, 0);
            default: return recent_base + $urandom_range(80, 0);  // reuses recent slots
        endcase
    endfunction

    function automatic t_num noise_number();
        if ($urandom_range(1, 0))
            return $urandom();
        // Near the last run: hits its slots with the same and newer epochs.
        return recent_base + $urandom_range(140, 0);
    endfunction

    // Well-formed run: set a base, add base..base+len-1 in shuffled order and
    // interleave as many takes. Takes ahead of their add leave a waiting request
    // that the matching add fills. A broken run replaces one add by the same
    // slot one epoch later, so the take for it stays waiting.
    task automatic run_sequence(input logic broken);
        t_num nums [SEQ_MAX_LEN];
        t_num swap;
        int   len;
        int   pick;
        int   adds_left;
        int   takes_left;
        len = $urandom_range(SEQ_MAX_LEN, 1);
        recent_base = pick_base();
        for (int i = 0; i < len; i++)
            nums[i] = recent_base + i;
        for (int i = len - 1; i > 0; i--) begin
            pick       = $urandom_range(i, 0);
            swap       = nums[i];
            nums[i]    = nums[pick];
            nums[pick] = swap;
        end
        if (broken)
            nums[0] = nums[0] + DEPTH_DEF;
        send_request(MODE_SET, recent_base);
        adds_left  = len;
        takes_left = len;
        while (adds_left > 0 || takes_left > 0) begin
            if (takes_left > 0 && (adds_left == 0 || $urandom_range(1, 0))) begin
                send_request(MODE_TAKE, $urandom());
                takes_left--;
            end else begin
                send_request(MODE_ADD, nums[len - adds_left]);
                adds_left--;
            end
        end
        if (broken)
            settle_pending();
    endtask

    // Loose requests of every kind, including the unused mode.
    task automatic run_noise();
        repeat ($urandom_range(6, 1)) begin
            case ($urandom_range(4, 0))
                0, 1:    send_request(MODE_ADD, noise_number());
                2:       send_request(MODE_TAKE, $urandom());
                3:       send_request(MODE_SET, noise_number());
                default: send_request(MODE_UNUSED, $urandom());
            endcase
        end
        settle_pending();
    endtask

    // Hard stop in case the block hangs.
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int random_start;
        rst_n                  <= 1'b0;
        req_if.valid           <= 1'b0;
        req_if.mode            <= MODE_ADD;
        req_if.sequence_number <= '0;
        rx_eager               <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. The block starts with expected number zero and every slot
        // empty; requests are held off by the slot clearing pass that follows reset.
        send_request(MODE_TAKE, 32'hFFFF_FFFF);   // slot 0 empty: take waits
        send_request(MODE_TAKE, 32'h0000_0000);   // take while waiting: ignored
        send_request(MODE_SET, 32'h0000_1234);    // set while waiting: ignored
        send_request(MODE_ADD, 32'd5);            // other number while waiting: stored only
        send_request(MODE_UNUSED, 32'hFFFF_FFFF); // unused mode: no effect
        send_request(MODE_ADD, 32'd0);            // fills the waiting take: delivers 0
        send_request(MODE_ADD, 32'd1);            // stored, nothing waiting
        send_request(MODE_TAKE, 32'd0);           // hit: delivers 1
        send_request(MODE_TAKE, 32'd0);           // slot 2 empty: waits
        send_request(MODE_ADD, 32'd2);            // delivers 2
        send_request(MODE_SET, 32'hFFFF_FFFF);
        send_request(MODE_ADD, 32'hFFFF_FFFF);
        send_request(MODE_TAKE, 32'd0);           // delivers all ones, counter wraps to 0
        send_request(MODE_TAKE, 32'd0);           // slot 0 still holds epoch 0: delivers 0
        send_request(MODE_SET, 32'd66);           // slot 2 holds epoch 0, 66 is epoch 1
        send_request(MODE_TAKE, 32'd0);           // stale epoch: waits
        send_request(MODE_ADD, 32'd66);           // delivers 66
        send_request(MODE_SET, 32'h8000_0000);
        send_request(MODE_ADD, 32'hAAAA_AAAA);
        send_request(MODE_ADD, 32'h5555_5555);
        send_request(MODE_ADD, 32'h8000_0000);
        send_request(MODE_TAKE, 32'h5555_5555);   // delivers top-bit number
        settle_pending();

        // Random part: mostly well-formed runs, the rest broken runs and noise.
        // Eager stretches on either side keep the pipeline full.
        random_start = sent_count;
        while (sent_count - random_start < RANDOM_ITEMS) begin
            tx_eager = ($urandom_range(3, 0) == 0);
            rx_eager <= ($urandom_range(3, 0) == 0);
            case ($urandom_range(9, 0))
                0, 1:    run_noise();
                2:       run_sequence(1'b1);
                default: run_sequence(1'b0);
            endcase
            // Now and then stop and let every delivery come out before going on.
            if ($urandom_range(7, 0) == 0)
                drain_deliveries();
        end
        drain_deliveries();

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
